@@ rtl/erot_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Euler rotation package
// Shared constants and the quarter-wave sine table for the rotation core.
// ----------------------------------------------------------------------------
package erot_pkg;

	// Angle and table geometry.
	localparam int ANGLE_BITS   = 16;
	localparam int QUARTER_BITS = ANGLE_BITS - 2;
	localparam int TABLE_BITS   = 8;
	localparam int INTERP_BITS  = QUARTER_BITS - TABLE_BITS;
	localparam int TABLE_DEPTH  = (1 << TABLE_BITS) + 1;
	localparam int IDX_BITS     = TABLE_BITS + 1;

	// Trig values are unsigned Q1.30 magnitudes, one is 2^30.
	localparam int TRIG_W = 31;
	localparam logic [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1) << 30;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef logic [TRIG_W-1:0] sine_tab_t [TABLE_DEPTH];
	typedef logic [63:0] den_tab_t [1:8];

	// Taylor series denominators (2k)(2k+1).
	localparam den_tab_t TAYLOR_DEN = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210, 64'd272};

	// Builds sin(i*pi/512) in Q30 with a series to x^17, clamped to [0, 1].
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		longint sum;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (i >= (1 << TABLE_BITS)) begin
				tab[i] = TRIG_ONE;
			end else begin
				x = (64'(i) * PI_Q30 + 64'd256) >> 9;
				x2 = (x * x) >> 30;
				t = x;
				sum = longint'(x);
				for (int k = 1; k <= 8; k++) begin
					t = ((t * x2) >> 30) / TAYLOR_DEN[k];
					if (k % 2 == 1) begin
						sum = sum - longint'(t);
					end else begin
						sum = sum + longint'(t);
					end
				end
				if (sum < 0) begin
					sum = 0;
				end
				if (sum > longint'(TRIG_ONE)) begin
					sum = longint'(TRIG_ONE);
				end
				tab[i] = TRIG_W'(sum);
			end
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage
`default_nettype wire

@@ rtl/vec3_euler_rotate_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Three-axis Euler rotation core
// Rotates a Q16.16 vector about X, then Y, then Z by binary angles.
// ----------------------------------------------------------------------------
// A new transaction is taken every clock cycle: busy is always low. Each
// result appears with done high, in order, for one cycle; the receiver must
// take it then. Each goes through the two-stage sine/cosine lookup followed
// by three two-stage axis rotations (products, then sum and saturation). Sine
// and cosine for the Y and Z axes are computed just in time from delayed
// angles.
module vec3_euler_rotate_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic signed [31:0]              vec_x,
	input  wire logic signed [31:0]              vec_y,
	input  wire logic signed [31:0]              vec_z,
	input  wire logic [15:0]                     angle_x,
	input  wire logic [15:0]                     angle_y,
	input  wire logic [15:0]                     angle_z,
	output logic                                 done,
	output logic signed [31:0]                   rot_x,
	output logic signed [31:0]                   rot_y,
	output logic signed [31:0]                   rot_z
);
	import erot_pkg::*;

	logic               valid_s1, valid_s2;
	logic signed [31:0] x_s1, y_s1, z_s1, x_s2, y_s2, z_s2;
	logic [15:0]        ay_s1, ay_s2, az_s1, az_s2, az_s3, az_s4;
	logic signed [31:0] sx, cx, sy, cy, sz, cz;
	logic               vx, vy;
	logic signed [31:0] x_a, y_a, z_a, x_b, y_b, z_b;

	assign busy = 1'b0;

	// Valid bits while the X-axis trig lookup runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	// Vector and later angles wait for their trig values.
	always_ff @(posedge clk) begin
		x_s1 <= vec_x;
		y_s1 <= vec_y;
		z_s1 <= vec_z;
		x_s2 <= x_s1;
		y_s2 <= y_s1;
		z_s2 <= z_s1;
		ay_s1 <= angle_y;
		ay_s2 <= ay_s1;
		az_s1 <= angle_z;
		az_s2 <= az_s1;
		az_s3 <= az_s2;
		az_s4 <= az_s3;
	end

	erot_trig u_trig_x (.clk(clk), .angle(ANGLE_BITS'(angle_x)), .sin_val(sx), .cos_val(cx));
	erot_trig u_trig_y (.clk(clk), .angle(ANGLE_BITS'(ay_s2)), .sin_val(sy), .cos_val(cy));
	erot_trig u_trig_z (.clk(clk), .angle(ANGLE_BITS'(az_s4)), .sin_val(sz), .cos_val(cz));

	// X axis: y and z turn, x passes.
	erot_axis u_axis_x (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s2),
		.a(y_s2), .b(z_s2), .pass(x_s2), .cos_val(cx), .sin_val(sx),
		.out_valid(vx), .a_out(y_a), .b_out(z_a), .pass_out(x_a)
	);

	// Y axis: z and x turn, y passes.
	erot_axis u_axis_y (
		.clk(clk), .arst_n(arst_n), .in_valid(vx),
		.a(z_a), .b(x_a), .pass(y_a), .cos_val(cy), .sin_val(sy),
		.out_valid(vy), .a_out(z_b), .b_out(x_b), .pass_out(y_b)
	);

	// Z axis: x and y turn, z passes.
	erot_axis u_axis_z (
		.clk(clk), .arst_n(arst_n), .in_valid(vy),
		.a(x_b), .b(y_b), .pass(z_b), .cos_val(cz), .sin_val(sz),
		.out_valid(done), .a_out(rot_x), .b_out(rot_y), .pass_out(rot_z)
	);

endmodule
`default_nettype wire

@@ rtl/erot_trig.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sine and cosine unit
// Two-stage table lookup with linear interpolation for one binary angle.
// ----------------------------------------------------------------------------
module erot_trig (
	input  wire logic                          clk,
	input  wire logic [erot_pkg::ANGLE_BITS-1:0] angle,
	output logic signed [31:0]                 sin_val,
	output logic signed [31:0]                 cos_val
);
	import erot_pkg::*;

	typedef struct packed {
		logic [TRIG_W-1:0]      lo;
		logic [TRIG_W-1:0]      hi;
		logic [INTERP_BITS-1:0] frac;
		logic                   neg;
	} lookup_t;

	lookup_t sin_s1;
	lookup_t cos_s1;

	// Folds an angle into the first quadrant and fetches both table neighbors.
	function automatic lookup_t fetch(input logic [ANGLE_BITS-1:0] a);
		lookup_t res;
		logic [QUARTER_BITS:0] p;
		logic [IDX_BITS-1:0]   idx;
		if (a[QUARTER_BITS]) begin
			p = (QUARTER_BITS+1)'(1 << QUARTER_BITS) - {1'b0, a[QUARTER_BITS-1:0]};
		end else begin
			p = {1'b0, a[QUARTER_BITS-1:0]};
		end
		idx = p[QUARTER_BITS:INTERP_BITS];
		res.lo = SINE_TAB[idx];
		if (idx == IDX_BITS'(1 << TABLE_BITS)) begin
			res.hi = TRIG_ONE;
		end else begin
			res.hi = SINE_TAB[idx + IDX_BITS'(1)];
		end
		res.frac = p[INTERP_BITS-1:0];
		res.neg = a[ANGLE_BITS-1];
		return res;
	endfunction

	// Interpolates between neighbors, rounding half up, then applies the sign.
	function automatic logic signed [31:0] blend(input lookup_t l);
		logic [TRIG_W+INTERP_BITS:0] acc;
		logic [TRIG_W-1:0]           mag;
		acc = (TRIG_W+INTERP_BITS+1)'(l.lo) *
			(TRIG_W+INTERP_BITS+1)'((INTERP_BITS+1)'(1 << INTERP_BITS) - {1'b0, l.frac})
			+ (TRIG_W+INTERP_BITS+1)'(l.hi) * (TRIG_W+INTERP_BITS+1)'(l.frac)
			+ (TRIG_W+INTERP_BITS+1)'(1 << (INTERP_BITS-1));
		mag = acc[TRIG_W+INTERP_BITS-1:INTERP_BITS];
		if (l.neg) begin
			return -$signed({1'b0, mag});
		end
		return $signed({1'b0, mag});
	endfunction

	// Stage one: table lookup. Cosine is sine a quarter turn ahead.
	always_ff @(posedge clk) begin
		sin_s1 <= fetch(angle);
		cos_s1 <= fetch(angle + ANGLE_BITS'(1 << QUARTER_BITS));
	end

	// Stage two: interpolation.
	always_ff @(posedge clk) begin
		sin_val <= blend(sin_s1);
		cos_val <= blend(cos_s1);
	end

endmodule
`default_nettype wire

@@ rtl/erot_axis.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Single-axis rotation
// Two-stage planar rotation: a' = a*c - b*s, b' = a*s + b*c, saturated.
// ----------------------------------------------------------------------------
module erot_axis (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	input  wire logic signed [31:0] pass,
	input  wire logic signed [31:0] cos_val,
	input  wire logic signed [31:0] sin_val,
	output logic                    out_valid,
	output logic signed [31:0]      a_out,
	output logic signed [31:0]      b_out,
	output logic signed [31:0]      pass_out
);
	import erot_pkg::*;

	logic               valid_s1;
	logic signed [32:0] ac_s1, bs_s1, as_s1, bc_s1;
	logic signed [31:0] pass_s1;

	// Rounds a Q30 product to nearest, ties toward plus infinity.
	function automatic logic signed [32:0] mulq(input logic signed [31:0] v,
		input logic signed [31:0] k);
		logic signed [63:0] prod;
		prod = v * k + 64'sd536870912;
		return prod[62:30];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) begin
			return 32'sh7fffffff;
		end
		if (v < -34'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Valid bits for both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			out_valid <= valid_s1;
		end
	end

	// Stage one: the four rounded products.
	always_ff @(posedge clk) begin
		ac_s1 <= mulq(a, cos_val);
		bs_s1 <= mulq(b, sin_val);
		as_s1 <= mulq(a, sin_val);
		bc_s1 <= mulq(b, cos_val);
		pass_s1 <= pass;
	end

	// Stage two: combine and saturate.
	always_ff @(posedge clk) begin
		a_out <= sat32(34'(ac_s1) - 34'(bs_s1));
		b_out <= sat32(34'(as_s1) + 34'(bc_s1));
		pass_out <= pass_s1;
	end

endmodule
`default_nettype wire
